[rtl/core/sbsm_pkg.sv]
`timescale 1ns / 1ps

package sbsm_pkg;

  // Bus access kinds
  typedef enum logic [1:0] {
    OP_CPU_READ  = 2'd0,
    OP_CPU_WRITE = 2'd1,
    OP_PPU_READ  = 2'd2,
    OP_PPU_WRITE = 2'd3
  } sbsm_op_e;

  // Target of a completed serial load, picked by address bits 14..13
  typedef enum logic [1:0] {
    SEL_CONTROL  = 2'd0,
    SEL_CHR_LOW  = 2'd1,
    SEL_CHR_HIGH = 2'd2,
    SEL_PRG      = 2'd3
  } sbsm_reg_sel_e;

  // Mirroring codes
  localparam logic [1:0] MIRROR_SINGLE_LOW = 2'd0;

  localparam int unsigned CountWidth  = 6;
  localparam int unsigned AddrWidth   = 16;
  localparam int unsigned MappedWidth = 19;

  localparam logic [CountWidth-1:0] PrgCountReset  = 6'd16;
  localparam logic [4:0]            ShiftEmpty     = 5'h10;
  localparam logic [4:0]            ControlReset   = 5'h1C;
  localparam logic [4:0]            ControlPrgMode = 5'h0C;

  typedef struct packed {
    sbsm_op_e               opcode;
    logic [AddrWidth-1:0]   address;
    logic [7:0]             write_data;
  } sbsm_in_t;

  typedef struct packed {
    logic                   hit;
    logic [MappedWidth-1:0] mapped_address;
    logic [1:0]             mirror_mode;
  } sbsm_out_t;

  // Banking state seen by the translation logic
  typedef struct packed {
    logic [CountWidth-1:0] prg_bank_count;
    logic [4:0]            control;
    logic [3:0]            prg_bank_sel;
    logic [4:0]            chr_low_bank;
    logic [4:0]            chr_high_bank;
  } sbsm_state_t;

endpackage

[rtl/core/sbsm_regs.sv]
`timescale 1ns / 1ps

// Serial load register and bank registers.
module sbsm_regs (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  sbsm_pkg::sbsm_in_t     item_i,
  input  logic                   cfg_we_i,
  input  logic [5:0]             cfg_wdata_i,
  output sbsm_pkg::sbsm_state_t  state_o,
  output logic [1:0]             mirror_next_o
);

  logic [5:0] prg_count_q;
  logic [4:0] load_shift_q, load_shift_d;
  logic [4:0] control_q, control_d;
  logic [3:0] prg_sel_q, prg_sel_d;
  logic [4:0] chr_low_q, chr_low_d;
  logic [4:0] chr_high_q, chr_high_d;
  logic [1:0] mirror_q, mirror_d;

  logic       serial_wr;
  logic [4:0] shifted;

  assign serial_wr = fire_i && (item_i.opcode == sbsm_pkg::OP_CPU_WRITE)
                     && item_i.address[15];
  assign shifted   = {item_i.write_data[0], load_shift_q[4:1]};

  always_comb begin
    load_shift_d = load_shift_q;
    control_d    = control_q;
    prg_sel_d    = prg_sel_q;
    chr_low_d    = chr_low_q;
    chr_high_d   = chr_high_q;
    mirror_d     = mirror_q;
    if (serial_wr) begin
      if (item_i.write_data[7]) begin
        load_shift_d = sbsm_pkg::ShiftEmpty;
        control_d    = control_q | sbsm_pkg::ControlPrgMode;
      end else if (!load_shift_q[0]) begin
        load_shift_d = shifted;
      end else begin
        // fifth bit: value complete
        load_shift_d = sbsm_pkg::ShiftEmpty;
        case (sbsm_pkg::sbsm_reg_sel_e'(item_i.address[14:13]))
          sbsm_pkg::SEL_CONTROL: begin
            control_d = shifted;
            mirror_d  = shifted[1:0];
          end
          sbsm_pkg::SEL_CHR_LOW:  chr_low_d  = shifted;
          sbsm_pkg::SEL_CHR_HIGH: chr_high_d = shifted;
          sbsm_pkg::SEL_PRG:      prg_sel_d  = shifted[3:0];
          default:                prg_sel_d  = prg_sel_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_count_q  <= sbsm_pkg::PrgCountReset;
      load_shift_q <= sbsm_pkg::ShiftEmpty;
      control_q    <= sbsm_pkg::ControlReset;
      prg_sel_q    <= '0;
      chr_low_q    <= '0;
      chr_high_q   <= '0;
      mirror_q     <= sbsm_pkg::MIRROR_SINGLE_LOW;
    end else begin
      if (cfg_we_i) begin
        prg_count_q <= cfg_wdata_i;
      end
      load_shift_q <= load_shift_d;
      control_q    <= control_d;
      prg_sel_q    <= prg_sel_d;
      chr_low_q    <= chr_low_d;
      chr_high_q   <= chr_high_d;
      mirror_q     <= mirror_d;
    end
  end

  assign state_o.prg_bank_count = prg_count_q;
  assign state_o.control        = control_q;
  assign state_o.prg_bank_sel   = prg_sel_q;
  assign state_o.chr_low_bank   = chr_low_q;
  assign state_o.chr_high_bank  = chr_high_q;
  assign mirror_next_o          = mirror_d;

  // marker bit never lost
  a_marker_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_shift_q != 5'd0)
    else $error("serial load register lost its marker bit");

  a_reset_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    serial_wr && item_i.write_data[7]
    |=> load_shift_q == sbsm_pkg::ShiftEmpty && control_q[3:2] == 2'b11)
    else $error("reset write did not clear the load and force PRG mode");

  a_no_write_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !serial_wr |=> $stable(load_shift_q) && $stable(control_q) && $stable(prg_sel_q)
                   && $stable(chr_low_q) && $stable(chr_high_q))
    else $error("bank state changed without a mapper write");

endmodule

[rtl/core/sbsm_xlate.sv]
`timescale 1ns / 1ps

// Address translation for one access.
module sbsm_xlate (
  input  sbsm_pkg::sbsm_in_t     item_i,
  input  sbsm_pkg::sbsm_state_t  state_i,
  input  logic [1:0]             mirror_i,
  output sbsm_pkg::sbsm_out_t    result_o
);

  logic [18:0] prg_addr;
  logic [18:0] chr_addr;
  logic [5:0]  last_bank;

  assign last_bank = state_i.prg_bank_count - 6'd1;

  always_comb begin
    if (state_i.control[3]) begin
      if (item_i.address[15:14] != 2'b11) begin
        prg_addr = {1'b0, state_i.prg_bank_sel, item_i.address[13:0]};
      end else begin
        // upper window fixed to the last bank, wraps in 512K
        prg_addr = {last_bank[4:0], item_i.address[13:0]};
      end
    end else begin
      prg_addr = {1'b0, state_i.prg_bank_sel[3:1], item_i.address[14:0]};
    end
  end

  always_comb begin
    if (state_i.control[4]) begin
      if (!item_i.address[12]) begin
        chr_addr = {2'b00, state_i.chr_low_bank, item_i.address[11:0]};
      end else begin
        chr_addr = {2'b00, state_i.chr_high_bank, item_i.address[11:0]};
      end
    end else begin
      chr_addr = {2'b00, state_i.chr_low_bank[4:1], item_i.address[12:0]};
    end
  end

  always_comb begin
    result_o.hit            = 1'b0;
    result_o.mapped_address = '0;
    result_o.mirror_mode    = mirror_i;
    case (item_i.opcode)
      sbsm_pkg::OP_CPU_READ: begin
        if (item_i.address[15]) begin
          result_o.hit            = 1'b1;
          result_o.mapped_address = prg_addr;
        end
      end
      sbsm_pkg::OP_CPU_WRITE: begin
        result_o.hit = 1'b0;
      end
      sbsm_pkg::OP_PPU_READ, sbsm_pkg::OP_PPU_WRITE: begin
        if (item_i.address[15:13] == 3'b000) begin
          result_o.hit            = 1'b1;
          result_o.mapped_address = chr_addr;
        end
      end
      default: begin
        result_o.hit = 1'b0;
      end
    endcase
  end

endmodule

[rtl/core/serial_bank_switch_mapper_unit.sv]
`timescale 1ns / 1ps

// Cartridge bank-switch mapper. Each item is one bus access (CPU read or write,
// PPU read or write) and yields one result item: hit flag, 19-bit cartridge
// address and the mirroring mode in force after that access. CPU writes at
// 0x8000 and up feed the 5-bit serial load register; bit 7 of the data aborts
// the load and forces 16K PRG mode. The block takes one item every cycle unless
// stalled; each item passes through the input register and then the result
// register, with the bank register update and the translation between them.
// Stall on the result side backs up through the two registers, so up to
// two items can be in flight. prg_bank_count is written through
// cfg_we_i/cfg_wdata_i, by the user only while idle; the block does not check.
module serial_bank_switch_mapper_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sbsm_pkg::sbsm_in_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sbsm_pkg::sbsm_out_t  out_item_o,
  input  logic                 cfg_we_i,
  input  logic [5:0]           cfg_wdata_i
);

  // input register
  logic               s1_valid_q;
  sbsm_pkg::sbsm_in_t s1_q;
  // result register
  logic                out_valid_q;
  sbsm_pkg::sbsm_out_t out_q;

  logic                  out_free;
  logic                  s1_fire;
  logic                  in_fire;
  sbsm_pkg::sbsm_state_t state;
  logic [1:0]            mirror_next;
  sbsm_pkg::sbsm_out_t   result;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_item_i;
    end
    if (s1_fire) begin
      out_q <= result;
    end
  end

  // bank state advances exactly when the item leaves the input register
  sbsm_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (s1_fire),
    .item_i       (s1_q),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .state_o      (state),
    .mirror_next_o(mirror_next)
  );

  sbsm_xlate u_xlate (
    .item_i  (s1_q),
    .state_i (state),
    .mirror_i(mirror_next),
    .result_o(result)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.hit |-> out_q.mapped_address == '0)
    else $error("miss carries a non-zero mapped address");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free |=> s1_valid_q && $stable(s1_q))
    else $error("held item in input register was lost or overwritten");

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

// Top-level bench for serial_bank_switch_mapper_unit.
// Every accepted item is run through the bench's own copy of the mapper
// state, and the expected translation is queued; results are popped
// in order and compared field by field.
module tb;

  // Cycles without any handshake before the run is declared hung
  localparam int IdleLimit = 1000;
  // Items per random phase; seven phases give at least 1855 in total
  localparam int PhaseItems = 265;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  sbsm_pkg::sbsm_in_t  in_item_i  = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  sbsm_pkg::sbsm_out_t out_item_o;
  logic               cfg_we_i    = 1'b0;
  logic [5:0]         cfg_wdata_i = '0;

  serial_bank_switch_mapper_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Mirror of the mapper's banking state, reset values as after rst_ni
  logic [5:0] bank_count_m = sbsm_pkg::PrgCountReset;
  logic [4:0] shift_m      = sbsm_pkg::ShiftEmpty;
  logic [4:0] ctrl_m       = sbsm_pkg::ControlReset;
  logic [3:0] prg_sel_m    = '0;
  logic [4:0] chr_lo_m     = '0;
  logic [4:0] chr_hi_m     = '0;
  logic [1:0] mirror_m     = sbsm_pkg::MIRROR_SINGLE_LOW;

  // Translations still owed by the block, oldest first
  sbsm_pkg::sbsm_out_t pending_translations[$];

  int  error_count     = 0;
  int  results_checked = 0;
  int  accesses_sent   = 0;
  int  bank_settings   = 0;
  int  op_tally[4]     = '{default: 0};
  int  idle_cycles     = 0;
  // When set, the matching side runs without gaps for a stretch
  bit  in_steady       = 1'b0;
  bit  out_steady      = 1'b0;

  // Work out the result of one accepted access and update the mirrored
  // state. Mirroring is reported after the access has taken effect.
  task automatic apply_bus_access(input sbsm_pkg::sbsm_in_t acc);
    sbsm_pkg::sbsm_out_t res;
    logic [5:0]  last_bank;
    logic [19:0] wide;
    logic        load_done;
    res = '0;
    case (acc.opcode)
      sbsm_pkg::OP_CPU_READ: begin
        if (acc.address >= 16'h8000) begin
          res.hit = 1'b1;
          if (ctrl_m[3]) begin
            // 16K mode: switchable bank low, last bank fixed at 0xC000
            if (acc.address < 16'hC000) begin
              res.mapped_address = {1'b0, prg_sel_m, acc.address[13:0]};
            end else begin
              last_bank = bank_count_m - 6'd1;  // wraps for a count of 0
              wide = {last_bank, acc.address[13:0]};
              res.mapped_address = wide[18:0];
            end
          end else begin
            // 32K mode ignores the low bank bit
            res.mapped_address = {1'b0, prg_sel_m[3:1], acc.address[14:0]};
          end
        end
      end
      sbsm_pkg::OP_CPU_WRITE: begin
        if (acc.address >= 16'h8000) begin
          if (acc.write_data[7]) begin
            // abort the serial load, force 16K PRG mode
            shift_m = sbsm_pkg::ShiftEmpty;
            ctrl_m  = ctrl_m | sbsm_pkg::ControlPrgMode;
          end else begin
            load_done = shift_m[0];
            shift_m   = {acc.write_data[0], shift_m[4:1]};
            if (load_done) begin
              case (sbsm_pkg::sbsm_reg_sel_e'(acc.address[14:13]))
                sbsm_pkg::SEL_CONTROL: begin
                  ctrl_m   = shift_m;
                  mirror_m = shift_m[1:0];
                end
                sbsm_pkg::SEL_CHR_LOW:  chr_lo_m = shift_m;
                sbsm_pkg::SEL_CHR_HIGH: chr_hi_m = shift_m;
                default:                prg_sel_m = shift_m[3:0];
              endcase
              shift_m = sbsm_pkg::ShiftEmpty;
            end
          end
        end
      end
      default: begin
        // PPU side: pattern tables only
        if (acc.address < 16'h2000) begin
          res.hit = 1'b1;
          if (ctrl_m[4]) begin
            if (acc.address < 16'h1000)
              res.mapped_address = {2'b00, chr_lo_m, acc.address[11:0]};
            else
              res.mapped_address = {2'b00, chr_hi_m, acc.address[11:0]};
          end else begin
            res.mapped_address = {2'b00, chr_lo_m[4:1], acc.address[12:0]};
          end
        end
      end
    endcase
    res.mirror_mode = mirror_m;
    pending_translations.push_back(res);
  endtask

  // Offer one item after a random gap and hold it until taken
  task automatic send_access(input sbsm_pkg::sbsm_op_e op, input logic [15:0] addr,
                             input logic [7:0] data);
    sbsm_pkg::sbsm_in_t acc;
    int                 gap;
    acc.opcode     = op;
    acc.address    = addr;
    acc.write_data = data;
    gap = in_steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= acc;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    apply_bus_access(acc);
    op_tally[op]++;
    accesses_sent++;
  endtask

  // Five serial writes, LSB first. Only the fifth address picks the target,
  // so the first four go to random addresses in the upper half.
  task automatic load_register(input sbsm_pkg::sbsm_reg_sel_e target,
                               input logic [4:0] value);
    logic [15:0] addr;
    for (int i = 0; i < 5; i++) begin
      if (i == 4)
        addr = {1'b1, target, 13'($urandom)};
      else
        addr = 16'h8000 | 16'($urandom);
      send_access(sbsm_pkg::OP_CPU_WRITE, addr, {1'b0, 6'($urandom), value[i]});
    end
  endtask

  // Write the bank count once the pipeline has drained
  task automatic set_bank_count(input logic [5:0] count);
    in_valid_i <= 1'b0;
    while (pending_translations.size() != 0) @(posedge clk_i);
    cfg_wdata_i <= count;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    bank_count_m = count;
    bank_settings++;
  endtask

  // State straight after reset, plus the miss cases
  task automatic test_reset_translation();
    send_access(sbsm_pkg::OP_CPU_READ,  16'h8000, 8'h00);
    send_access(sbsm_pkg::OP_CPU_READ,  16'hFFFF, 8'hFF);  // fixed last bank
    send_access(sbsm_pkg::OP_CPU_READ,  16'h0000, 8'h00);  // miss below 0x8000
    send_access(sbsm_pkg::OP_PPU_READ,  16'h0000, 8'hFF);
    send_access(sbsm_pkg::OP_PPU_WRITE, 16'h1FFF, 8'h00);
    send_access(sbsm_pkg::OP_PPU_READ,  16'hFFFF, 8'h00);  // miss above pattern tables
    send_access(sbsm_pkg::OP_CPU_WRITE, 16'h7FFF, 8'hFF);  // low write, no effect
  endtask

  // Serial loads: control, PRG, an aborted load and a write below the window
  task automatic test_serial_loads();
    load_register(sbsm_pkg::SEL_CONTROL, 5'b10011);  // 4K CHR, 32K PRG, horizontal
    send_access(sbsm_pkg::OP_CPU_READ, 16'hC000, 8'h00);
    send_access(sbsm_pkg::OP_PPU_READ, 16'h1000, 8'h00);
    load_register(sbsm_pkg::SEL_PRG, 5'h0F);
    send_access(sbsm_pkg::OP_CPU_READ, 16'hFFFF, 8'h00);
    send_access(sbsm_pkg::OP_CPU_WRITE, 16'h8000, 8'h01);
    send_access(sbsm_pkg::OP_CPU_WRITE, 16'hA000, 8'h7E);
    send_access(sbsm_pkg::OP_CPU_WRITE, 16'hFFFF, 8'h80);  // abort, back to 16K mode
    send_access(sbsm_pkg::OP_CPU_READ, 16'hC000, 8'h00);
    send_access(sbsm_pkg::OP_CPU_WRITE, 16'h0000, 8'h01);
  endtask

  // Random traffic under one bank count. Most of it is well-formed serial
  // loads and translations; the rest is aborted loads and raw noise.
  task automatic test_random_traffic(input logic [5:0] count);
    int start_count;
    int pick;
    int n;
    set_bank_count(count);
    start_count = accesses_sent;
    while (accesses_sent - start_count < PhaseItems) begin
      if ($urandom_range(0, 39) == 0) begin
        in_steady  = ($urandom_range(0, 2) == 0);
        out_steady = ($urandom_range(0, 2) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        load_register(sbsm_pkg::sbsm_reg_sel_e'($urandom_range(0, 3)), 5'($urandom));
      end else if (pick < 35) begin
        n = $urandom_range(0, 3);
        repeat (n) send_access(sbsm_pkg::OP_CPU_WRITE, 16'h8000 | 16'($urandom),
                               8'($urandom_range(0, 127)));
        send_access(sbsm_pkg::OP_CPU_WRITE, 16'h8000 | 16'($urandom),
                    8'h80 | 8'($urandom));
      end else if (pick < 55) begin
        send_access(sbsm_pkg::OP_CPU_READ, ($urandom_range(0, 4) == 0) ? 16'($urandom) :
                    16'h8000 | 16'($urandom), 8'($urandom));
      end else if (pick < 80) begin
        send_access(($urandom_range(0, 1) == 1) ? sbsm_pkg::OP_PPU_READ :
                    sbsm_pkg::OP_PPU_WRITE,
                    ($urandom_range(0, 4) == 0) ? 16'($urandom) :
                    16'($urandom_range(0, 16'h1FFF)), 8'($urandom));
      end else if (pick < 90) begin
        send_access(sbsm_pkg::sbsm_op_e'($urandom_range(0, 3)), 16'($urandom),
                    8'($urandom));
      end else begin
        send_access(sbsm_pkg::OP_CPU_WRITE, 16'($urandom_range(0, 16'h7FFF)),
                    8'($urandom));
      end
    end
    in_steady  = 1'b0;
    out_steady = 1'b0;
  endtask

  // Result side: stall for a random number of cycles before each result
  initial begin : result_stall
    int hold;
    @(posedge rst_ni);
    forever begin
      hold = out_steady ? 0 : $urandom_range(0, 13);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o || out_stall_i) @(posedge clk_i);
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    sbsm_pkg::sbsm_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_translations.size() == 0) begin
        $display("%0t: result with no access pending: %p", $time, out_item_o);
        error_count++;
      end else begin
        want = pending_translations.pop_front();
        results_checked++;
        if (out_item_o.hit !== want.hit) begin
          $display("%0t: hit expected %0d got %0d", $time, want.hit, out_item_o.hit);
          error_count++;
        end
        if (out_item_o.mapped_address !== want.mapped_address) begin
          $display("%0t: mapped_address expected %h got %h", $time,
                   want.mapped_address, out_item_o.mapped_address);
          error_count++;
        end
        if (out_item_o.mirror_mode !== want.mirror_mode) begin
          $display("%0t: mirror_mode expected %0d got %0d", $time,
                   want.mirror_mode, out_item_o.mirror_mode);
          error_count++;
        end
      end
    end
  end

  // Hang detection: any handshake on either side restarts the count
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, IdleLimit, pending_translations.size());
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_translation();
    test_serial_loads();
    // extremes first, then the reset value, then the wrapping counts, then one in range at random
    test_random_traffic(6'd1);
    test_random_traffic(6'd32);
    test_random_traffic(sbsm_pkg::PrgCountReset);
    test_random_traffic(6'd0);
    test_random_traffic(6'd63);
    test_random_traffic(6'd33);
    test_random_traffic(6'($urandom_range(2, 31)));

    // drain the pending translations before the summary
    in_valid_i <= 1'b0;
    while (pending_translations.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);

    $display("Checked %0d results from %0d items: %0d cpu reads, %0d cpu writes, %0d ppu",
             results_checked, accesses_sent, op_tally[sbsm_pkg::OP_CPU_READ],
             op_tally[sbsm_pkg::OP_CPU_WRITE],
             op_tally[sbsm_pkg::OP_PPU_READ] + op_tally[sbsm_pkg::OP_PPU_WRITE]);
    $display("Bank count written %0d times, covering 1, 32 and the wrapping values 0, 33, 63",
             bank_settings);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
